// File: hdl/qrp_pkg.sv
// Shared widths, types and CORDIC helpers for the quaternion to roll/pitch block.
`timescale 1ns / 1ps
`default_nettype none

package qrp_pkg;

  // CORDIC micro-rotations, limited by the arctangent table
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned TABLE_LEN    = 24;
  localparam int unsigned NSTEP        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Datapath widths
  localparam int unsigned QW   = 16;  // quaternion component
  localparam int unsigned PRW  = 32;  // 16x16 product
  localparam int unsigned PW   = 34;  // s, c, p at 30 fraction bits
  localparam int unsigned SW   = 31;  // in-range pitch argument
  localparam int unsigned NW   = 61;  // radicand, up to 2^60
  localparam int unsigned SQW  = 62;  // square root working width
  localparam int unsigned RW   = 31;  // square root result
  localparam int unsigned CW   = 38;  // CORDIC x / y
  localparam int unsigned ZW   = 35;  // CORDIC angle accumulator
  localparam int unsigned FRAC = 30;
  localparam int unsigned SQ_STEPS = 31;

  localparam int unsigned ROLL_W  = 16;
  localparam int unsigned PITCH_W = 15;

  localparam logic signed [ZW-1:0] PI_Q30    = ZW'(64'sd3373259426);
  localparam logic signed [PW-1:0] ONE_Q30   = PW'(64'sd1073741824);
  localparam logic signed [17:0]   ROLL_MAX  = 18'sd25736;
  localparam logic signed [17:0]   PITCH_MAX = 18'sd12868;

  // atan(2^-i) * 2^30, truncated
  localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
    30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
    30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
    30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  // Values carried alongside the square root
  typedef struct packed {
    logic signed [PW-1:0] s;
    logic signed [PW-1:0] c;
    logic signed [SW-1:0] p;
    logic                 sat_pos;
    logic                 sat_neg;
  } side_t;

  // One CORDIC vectoring lane
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  // Fold the left half plane onto the right one
  function automatic lane_t cordic_pre(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x[CW-1]) begin
      l.x = -x;
      l.y = -y;
      l.z = y[CW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      l.x = x;
      l.y = y;
      l.z = '0;
    end
    return l;
  endfunction

  // One micro-rotation towards y = 0
  function automatic lane_t cordic_step(lane_t l, int unsigned i);
    lane_t                r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] a;
    dx = l.y >>> i;
    dy = l.x >>> i;
    a  = $signed({{(ZW-30){1'b0}}, ATAN_Q30[i]});
    r  = l;
    if (!l.y[CW-1]) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + a;
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/qrp_front.sv
// Front end: products, roll/pitch arguments and the pitch radicand.
`timescale 1ns / 1ps
`default_nettype none

module qrp_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire logic signed [15:0]        quat_x_i,
  input  wire logic signed [15:0]        quat_y_i,
  input  wire logic signed [15:0]        quat_z_i,
  input  wire logic signed [15:0]        quat_w_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output logic [qrp_pkg::NW-1:0]         n_o,
  output qrp_pkg::side_t                 side_o
);
  import qrp_pkg::*;

  localparam int unsigned NS = 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // stage 0: products
  logic signed [PRW-1:0] wx_q, yz_q, wy_q, zx_q, xx_q, yy_q;
  // stage 1: arguments
  side_t                 s1_q;
  // stage 2: square of the pitch argument
  side_t                 s2_q;
  logic [59:0]           p2_q;
  // stage 3: radicand
  side_t                 s3_q;
  logic [NW-1:0]         n_q;

  logic signed [PW-1:0]  s_d, c_d, p_d;
  logic signed [SQW-1:0] sq_d;

  // stall chain, a stage moves when it is empty or its successor moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign n_o     = n_q;
  assign side_o  = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  // argument arithmetic
  always_comb begin
    s_d  = (PW'(wx_q) + PW'(yz_q)) <<< 1;
    c_d  = ONE_Q30 - ((PW'(xx_q) + PW'(yy_q)) <<< 1);
    p_d  = (PW'(wy_q) - PW'(zx_q)) <<< 1;
    sq_d = SQW'(s1_q.p) * SQW'(s1_q.p);
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
    end
    if (en[1] && v_q[0]) begin
      s1_q.s       <= s_d;
      s1_q.c       <= c_d;
      s1_q.p       <= p_d[SW-1:0];
      s1_q.sat_pos <= (p_d >= ONE_Q30);
      s1_q.sat_neg <= (p_d <= -ONE_Q30);
    end
    if (en[2] && v_q[1]) begin
      s2_q <= s1_q;
      p2_q <= sq_d[59:0];
    end
    if (en[3] && v_q[2]) begin
      s3_q <= s2_q;
      n_q  <= (NW'(1) << 60) - NW'(p2_q);
    end
  end

endmodule

`default_nettype wire

// File: hdl/qrp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module qrp_isqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire logic [qrp_pkg::NW-1:0]    n_i,
  input  wire qrp_pkg::side_t            side_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output logic [qrp_pkg::RW-1:0]         root_o,
  output qrp_pkg::side_t                 side_o
);
  import qrp_pkg::*;

  localparam int unsigned NS = SQ_STEPS;

  logic [NS-1:0]  v_q;
  logic [NS-1:0]  en;
  logic [SQW-1:0] n_q    [NS];
  logic [SQW-1:0] r_q    [NS];
  side_t          side_q [NS];

  // stall chain
  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign root_o  = r_q[NS-1][RW-1:0];
  assign side_o  = side_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  // one restoring step per stage, trial bit falls by a factor of four
  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NS - 1 - k));
    logic [SQW-1:0] n_prev, r_prev, trial, n_d, r_d;
    side_t          side_prev;
    logic           load;

    if (k == 0) begin : g_first
      assign n_prev    = SQW'(n_i);
      assign r_prev    = '0;
      assign side_prev = side_i;
      assign load      = en[0] && valid_i;
    end else begin : g_next
      assign n_prev    = n_q[k-1];
      assign r_prev    = r_q[k-1];
      assign side_prev = side_q[k-1];
      assign load      = en[k] && v_q[k-1];
    end

    always_comb begin
      trial = r_prev + BIT;
      if (n_prev >= trial) begin
        n_d = n_prev - trial;
        r_d = (r_prev >> 1) + BIT;
      end else begin
        n_d = n_prev;
        r_d = r_prev >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (load) begin
        n_q[k]    <= n_d;
        r_q[k]    <= r_d;
        side_q[k] <= side_prev;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/qrp_cordic.sv
// Unrolled CORDIC vectoring pipeline, roll and pitch lanes side by side.
`timescale 1ns / 1ps
`default_nettype none

module qrp_cordic (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic signed [qrp_pkg::CW-1:0] roll_y_i,
  input  wire logic signed [qrp_pkg::CW-1:0] roll_x_i,
  input  wire logic signed [qrp_pkg::CW-1:0] pitch_y_i,
  input  wire logic signed [qrp_pkg::CW-1:0] pitch_x_i,
  input  wire logic [1:0]                   flag_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output qrp_pkg::lane_t                    roll_o,
  output qrp_pkg::lane_t                    pitch_o,
  output logic [1:0]                        flag_o
);
  import qrp_pkg::*;

  // pre-rotation stage plus one stage per micro-rotation
  localparam int unsigned NS = NSTEP + 1;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  lane_t         roll_q  [NS];
  lane_t         pitch_q [NS];
  logic [1:0]    flag_q  [NS];

  // stall chain
  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign roll_o  = roll_q[NS-1];
  assign pitch_o = pitch_q[NS-1];
  assign flag_o  = flag_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  // pre-rotation
  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      roll_q[0]  <= cordic_pre(roll_y_i, roll_x_i);
      pitch_q[0] <= cordic_pre(pitch_y_i, pitch_x_i);
      flag_q[0]  <= flag_i;
    end
  end

  // micro-rotations
  for (genvar k = 1; k < NS; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en[k] && v_q[k-1]) begin
        roll_q[k]  <= cordic_step(roll_q[k-1], k - 1);
        pitch_q[k] <= cordic_step(pitch_q[k-1], k - 1);
        flag_q[k]  <= flag_q[k-1];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/quaternion_to_roll_pitch.sv
// Top level: quaternion (x, y, z, w) in Q1.15 to roll in Q3.13 and pitch in Q2.13.
// Pipeline: 4 front-end stages, 31 square root stages, 17 CORDIC
// stages (pre-rotation and 16 micro-rotations) and the output register.
// Throughput one transaction per cycle; every stage holds under back-pressure.
// Reset clears the valid bits of all stages and of the output register; no other state.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_roll_pitch (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // roll_angle[15:0], pitch_angle[30:16], zero
);
  import qrp_pkg::*;

  logic           f_valid, f_ready;
  logic [NW-1:0]  f_n;
  side_t          f_side;
  logic           q_valid, q_ready;
  logic [RW-1:0]  q_root;
  side_t          q_side;
  logic           c_valid, c_ready;
  lane_t          c_roll, c_pitch;
  logic [1:0]     c_flag;

  logic                   out_en;
  logic                   tvalid_q;
  logic signed [15:0]     roll_q;
  logic signed [14:0]     pitch_q;
  logic signed [17:0]     roll_d, pitch_d;

  // round 30 fraction bits to 13, ties upward, then clamp
  function automatic logic signed [17:0] to_q13(logic signed [ZW-1:0] z,
                                                logic signed [17:0] lim);
    logic signed [ZW-1:0] t;
    logic signed [17:0]   r;
    t = z + ZW'(1 << 16);
    r = 18'(t >>> 17);
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  qrp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .quat_x_i (s_axis_tdata[15:0]),
    .quat_y_i (s_axis_tdata[31:16]),
    .quat_z_i (s_axis_tdata[47:32]),
    .quat_w_i (s_axis_tdata[63:48]),
    .valid_o  (f_valid),
    .ready_i  (f_ready),
    .n_o      (f_n),
    .side_o   (f_side)
  );

  qrp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .n_i     (f_n),
    .side_i  (f_side),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .root_o  (q_root),
    .side_o  (q_side)
  );

  qrp_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .ready_o   (q_ready),
    .roll_y_i  (CW'(q_side.s)),
    .roll_x_i  (CW'(q_side.c)),
    .pitch_y_i (CW'(q_side.p)),
    .pitch_x_i (CW'($signed({1'b0, q_root}))),
    .flag_i    ({q_side.sat_pos, q_side.sat_neg}),
    .valid_o   (c_valid),
    .ready_i   (c_ready),
    .roll_o    (c_roll),
    .pitch_o   (c_pitch),
    .flag_o    (c_flag)
  );

  // final angles with the special cases
  always_comb begin
    roll_d = c_roll.zero ? '0 : to_q13(c_roll.z, ROLL_MAX);
    if (c_flag[1]) begin
      pitch_d = PITCH_MAX;
    end else if (c_flag[0]) begin
      pitch_d = -PITCH_MAX;
    end else begin
      pitch_d = to_q13(c_pitch.z, PITCH_MAX);
    end
  end

  // output register
  assign out_en  = !tvalid_q || m_axis_tready;
  assign c_ready = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (out_en) begin
      tvalid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && c_valid) begin
      roll_q  <= roll_d[15:0];
      pitch_q <= pitch_d[14:0];
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = {1'b0, pitch_q, roll_q};

endmodule

`default_nettype wire

// File: sim/quaternion_to_roll_pitch_test.sv
// Self-checking testbench for the quaternion to roll/pitch block.
`timescale 1ns / 1ps

module quaternion_to_roll_pitch_test;

  import qrp_pkg::*;

  localparam int LATENCY    = 53;
  localparam int N_RANDOM   = 1830;
  localparam int WDOG_LIMIT = 20000;
  localparam longint PI30   = 64'sd3373259426;
  localparam longint ONE30  = 64'sd1073741824;

  // x in the lowest bits, as on the bus
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } quat_t;

  // roll in the lowest bits, as on the bus
  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  // Directed row: quaternion, optional typed-in answer
  typedef struct {
    quat_t   q;
    bit      known;
    angles_t a;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // quat_x, quat_y, quat_z, quat_w
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // roll_angle[15:0], pitch_angle[30:16], zero

  angles_t expected_angles[$];
  int      n_fail;
  int      n_sent;
  int      n_recv;
  int      idle_cnt;
  bit      calm;         // no idling in the last part
  bit      hold_off;     // long receiver stall
  logic [63:0] bit_seen1, bit_seen0;

  quaternion_to_roll_pitch i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Floor division by 2^s
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, angle at 30 fraction bits
  function automatic longint vector_angle(longint y, longint x);
    longint a, dx, dy;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      a = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < int'(NSTEP); i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; a += longint'(ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; a -= longint'(ATAN_Q30[i]);
      end
    end
    return a;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = floor_shr(a + (64'sd1 <<< 16), 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t predict_angles(quat_t q);
    longint x, y, z, w, s, c, p, r, pt;
    angles_t res;
    x = q.x; y = q.y; z = q.z; w = q.w;
    s = 2 * (w * x + y * z);
    c = ONE30 - 2 * (x * x + y * y);
    p = 2 * (w * y - z * x);
    r = round_q13(vector_angle(s, c), 25736);
    if (p >= ONE30) pt = 12868;
    else if (p <= -ONE30) pt = -12868;
    else pt = round_q13(vector_angle(p, int_sqrt((64'sd1 <<< 60) - p * p)), 12868);
    res.roll  = r[15:0];
    res.pitch = pt[14:0];
    return res;
  endfunction

  function automatic row_t mk(int x, int y, int z, int w, bit k = 0, int r = 0,
                              int pt = 0);
    row_t t;
    t.q = {16'(w), 16'(z), 16'(y), 16'(x)};
    t.known = k;
    t.a = {15'(pt), 16'(r)};
    return t;
  endfunction

  // Biased random component: extremes, small, or full range
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly near-unit quaternions, the rest anything
  function automatic quat_t rand_quat();
    quat_t q;
    real a, b, c, d, n;
    if ($urandom_range(0, 3) == 0) begin
      q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    end else begin
      a = real'(int'($urandom_range(0, 2000)) - 1000);
      b = real'(int'($urandom_range(0, 2000)) - 1000);
      c = real'(int'($urandom_range(0, 2000)) - 1000);
      d = real'(int'($urandom_range(0, 2000)) - 1000);
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      q.x = 16'($rtoi(a / n * 32767.0));
      q.y = 16'($rtoi(b / n * 32767.0));
      q.z = 16'($rtoi(c / n * 32767.0));
      q.w = 16'($rtoi(d / n * 32767.0));
    end
    return q;
  endfunction

  // Offer one transaction and wait for it to be accepted; tvalid stays high
  task automatic send_quat(quat_t q, bit known, angles_t a);
    angles_t e;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    do @(posedge clk_i); while (!s_axis_tready);
    e = known ? a : predict_angles(q);
    expected_angles.insert(expected_angles.size(), e);
    bit_seen1 |= q;
    bit_seen0 |= ~q;
    n_sent++;
    @(negedge clk_i);
  endtask

  // Receiver stalls
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker and watchdog
  initial begin
    angles_t got, exp_a;
    idle_cnt = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          !rst_ni) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[30:0];
        n_recv++;
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, got);
          n_fail++;
        end else begin
          exp_a = expected_angles.pop_front();
          if (got.roll !== exp_a.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll, got.roll);
            n_fail++;
          end
          if (got.pitch !== exp_a.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch,
                     got.pitch);
            n_fail++;
          end
          if (m_axis_tdata[31] !== 1'b0) begin
            $display("%0t: pad bit expected 0 actual %b", $time, m_axis_tdata[31]);
            n_fail++;
          end
        end
      end
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("FAIL quaternion_to_roll_pitch");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    row_t rows[$];
    angles_t none;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    calm = 0; hold_off = 0;
    n_fail = 0; n_sent = 0; n_recv = 0;
    bit_seen1 = '0; bit_seen0 = '0;
    none = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Identity, zero args, rotation by pi, clamps, extremes
    rows.insert(rows.size(), mk(0, 0, 0, 32767, 1, 0, 0));
    rows.insert(rows.size(), mk(0, 0, 0, 0, 1, 0, 0));          // c = 1 only, roll 0
    rows.insert(rows.size(), mk(32767, 0, 0, 0));               // cosine negative, sine zero
    rows.insert(rows.size(), mk(-32768, 0, 0, 0, 1, 25736, 0)); // exactly +pi
    rows.insert(rows.size(), mk(0, 32767, 0, 0));
    rows.insert(rows.size(), mk(0, -32768, 0, 0));
    rows.insert(rows.size(), mk(0, 23170, 0, 23170));           // pitch near +pi/2
    rows.insert(rows.size(), mk(0, 32767, 0, 32767, 1, 25736, 12868));   // pitch clamp +
    rows.insert(rows.size(), mk(0, -32768, 0, 32767, 1, 25736, -12868)); // pitch clamp -
    rows.insert(rows.size(), mk(23170, 0, 0, 23170));           // roll pi/2
    rows.insert(rows.size(), mk(-23170, 0, 0, 23170));          // roll -pi/2
    rows.insert(rows.size(), mk(32767, 0, 0, -1));              // sine negative, left half
    rows.insert(rows.size(), mk(32767, 0, 0, 1));
    rows.insert(rows.size(), mk(-32768, -32768, -32768, -32768));
    rows.insert(rows.size(), mk(32767, 32767, 32767, 32767));
    rows.insert(rows.size(), mk(-32768, 32767, -32768, 32767));
    rows.insert(rows.size(), mk(1, 1, 1, 1));
    rows.insert(rows.size(), mk(-1, -1, -1, -1));
    rows.insert(rows.size(), mk(16384, 16384, 16384, 16384));
    rows.insert(rows.size(), mk(0, 0, 32767, 0));
    foreach (rows[i]) send_quat(rows[i].q, rows[i].known, rows[i].known ? rows[i].a : none);

    // Random body; a long receiver hold-off early, a drain pause midway
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) hold_off = 1'b1;
      if (i == 900) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (expected_angles.size() != 0);
      end
      if (i == N_RANDOM - 300) calm = 1'b1;
      send_quat(rand_quat(), 0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_angles.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (bit_seen1 != '1 || bit_seen0 != '1) begin
      $display("%0t: input bit coverage incomplete, ones %h zeros %h", $time,
               bit_seen1, bit_seen0);
      n_fail++;
    end
    $display("Run covered %0d quaternions (directed edge cases and random), %0d results",
             n_sent, n_recv);
    $display("with random stalls on both sides, a long output stall and a drain pause.");
    if (n_fail == 0) begin
      $display("PASS quaternion_to_roll_pitch");
    end else begin
      $display("FAIL quaternion_to_roll_pitch");
    end
    $finish;
  end

endmodule
